// ===== rtl/core/twfb_pkg.sv =====
package twfb_pkg;

	localparam int unsigned MS_PER_SEC = 1000;
	localparam int unsigned FRAC_BITS = 10;

	localparam int unsigned STEP_W = 17;
	localparam int unsigned SEC_W = 32;
	localparam int unsigned MSEC_W = 10;
	localparam int unsigned VAL_W = 48;
	localparam int unsigned SUM_W = 64;
	localparam int unsigned CNT_W = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned WIN_W = SEC_W + 2;
	localparam int unsigned MS_W = 46;
	localparam int unsigned WHOLE_W = VAL_W + FRAC_BITS;
	localparam int unsigned OV_W = 43;
	localparam int unsigned PROD_W = WHOLE_W + OV_W;
	localparam int unsigned DIV_CNT_W = $clog2(PROD_W + 1);
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_STEP = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

	localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_ROLLOUT = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_TRUNC = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROLL_RD,
		ST_ROLL_EMIT,
		ST_SAVE,
		ST_ALIGN,
		ST_CHECK,
		ST_WIN,
		ST_MUL,
		ST_DIV,
		ST_ACC,
		ST_NEXT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/core/time_window_flow_binner.sv =====
// channel  | handshake          | payload
// in       | in_valid, in_stall | kind, start_sec, start_msec, end_sec, end_msec, flow_value
// out      | out_valid, out_stall | status, window_begin, window_sum, window_count
// cfg      | cfg_we             | cfg_index, cfg_data
//
// roll word: reads the head window into the output register and advances the ring head
// save word: realigns on the first save or after an idle gap past the timeout; skips
//   untouched windows, adds the whole value for a zero-length flow and, for every other
//   touched window, runs a shift-add multiply, then the shared divider
// one word in flight; in_stall is high from accept until the result is loaded
// reset clears ring state and all window valid bits; no clearing pass
module time_window_flow_binner import twfb_pkg::*; #(
	parameter int unsigned NUM_WINDOWS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       kind,
	input  logic [SEC_W-1:0]           start_sec,
	input  logic [MSEC_W-1:0]          start_msec,
	input  logic [SEC_W-1:0]           end_sec,
	input  logic [MSEC_W-1:0]          end_msec,
	input  logic signed [VAL_W-1:0]    flow_value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [STATUS_W-1:0]        status,
	output logic [SEC_W-1:0]           window_begin,
	output logic signed [SUM_W-1:0]    window_sum,
	output logic [CNT_W-1:0]           window_count
);

	localparam int unsigned AW = $clog2(NUM_WINDOWS);
	localparam int unsigned ENT_W = SUM_W + CNT_W;

	state_t state_q, state_d;

	logic [STEP_W-1:0] step_q;
	logic [SEC_W-1:0]  tmo_q;
	logic [STEP_W-1:0] s_eff;

	logic [SEC_W-1:0]  fs_q, ls_q;
	logic [MSEC_W-1:0] fm_q, lm_q;
	logic [VAL_W-1:0]  val_q;

	logic                   started_q;
	logic [SEC_W-1:0]       db_q;
	logic [AW-1:0]          head_q;
	logic [NUM_WINDOWS-1:0] vld_q;

	logic [AW-1:0]           i_q;
	logic [WIN_W-1:0]        wb_q;
	logic signed [MS_W-1:0]  first_ms_q, last_ms_q, dur_q;
	logic [PROD_W-1:0]       mcand_q, prod_q;
	logic [OV_W-1:0]         mplier_q;
	logic [SUM_W-1:0]        share_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [SEC_W-1:0]    res_begin_q;
	logic [SUM_W-1:0]    res_sum_q;
	logic [CNT_W-1:0]    res_count_q;
	logic                out_valid_q;

	// sequencer outputs
	logic          div_start;
	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic          load_out;

	logic [PROD_W-1:0] div_dividend, div_quot;
	logic [OV_W-1:0]   div_divisor, div_rem;
	div_stat_t         div_st;
	logic [ENT_W-1:0]  ram_rdata, ram_wdata;

	// datapath terms
	logic                    neg;
	logic [VAL_W-1:0]        mag;
	logic [WHOLE_W-1:0]      whole;
	logic [WIN_W-1:0]        we_w, end_w;
	logic                    hit;
	logic signed [MS_W-1:0]  hi_ms, lo_ms, wb_ms, we_ms, ov;
	logic [OV_W-1:0]         ov_c;
	logic [AW:0]             slot_sum;
	logic [AW-1:0]           slot;
	logic signed [WIN_W-1:0] gap;
	logic                    need_align;
	logic [SUM_W-1:0]        old_sum;
	logic [CNT_W-1:0]        old_cnt;

	assign s_eff = (step_q == '0) ? STEP_W'(1) : step_q;
	assign neg = val_q[VAL_W-1];
	assign mag = neg ? (VAL_W'(0) - val_q) : val_q;
	assign whole = {mag, FRAC_BITS'(0)};

	assign we_w = wb_q + WIN_W'(s_eff);
	assign end_w = WIN_W'(db_q) + WIN_W'(NUM_WINDOWS) * WIN_W'(s_eff);
	assign hit = (wb_q <= WIN_W'(ls_q)) && (we_w >= WIN_W'(fs_q));

	assign wb_ms = $signed(MS_W'(wb_q) * MS_W'(MS_PER_SEC));
	assign we_ms = $signed(MS_W'(we_w) * MS_W'(MS_PER_SEC));
	assign hi_ms = (last_ms_q < we_ms) ? last_ms_q : we_ms;
	assign lo_ms = (first_ms_q > wb_ms) ? first_ms_q : wb_ms;
	assign ov = hi_ms - lo_ms;
	assign ov_c = ov[MS_W-1] ? '0 : ov[OV_W-1:0];

	assign slot_sum = {1'b0, head_q} + {1'b0, i_q};
	assign slot = (slot_sum >= (AW+1)'(NUM_WINDOWS)) ?
		AW'(slot_sum - (AW+1)'(NUM_WINDOWS)) : slot_sum[AW-1:0];

	assign gap = $signed(WIN_W'(fs_q)) - $signed(WIN_W'(db_q));
	assign need_align = !started_q || (gap > $signed(WIN_W'(tmo_q)));

	// entry that was cleared reads as zero
	assign old_sum = vld_q[slot] ? ram_rdata[ENT_W-1:CNT_W] : '0;
	assign old_cnt = vld_q[slot] ? ram_rdata[CNT_W-1:0] : '0;
	assign ram_wdata = {neg ? (old_sum - share_q) : (old_sum + share_q), old_cnt + 1'b1};

	assign div_dividend = (state_q == ST_SAVE) ? PROD_W'(fs_q) : prod_q;
	assign div_divisor = (state_q == ST_SAVE) ? OV_W'(s_eff) : dur_q[OV_W-1:0];

	twfb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quot     (div_quot),
		.rem      (div_rem),
		.stat     (div_st)
	);

	twfb_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NUM_WINDOWS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = kind ? ST_ROLL_RD : ST_SAVE;
				end
			end
			ST_ROLL_RD: state_d = ST_ROLL_EMIT;
			ST_ROLL_EMIT: state_d = ST_DONE;
			ST_SAVE: state_d = need_align ? ST_ALIGN : ST_CHECK;
			ST_ALIGN: begin
				if (div_st.done) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: state_d = (end_w < WIN_W'(ls_q)) ? ST_DONE : ST_WIN;
			ST_WIN: begin
				priority if (!hit) begin
					state_d = ST_NEXT;
				end else if (dur_q <= 0) begin
					state_d = ST_ACC;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mplier_q == '0) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_st.done) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: state_d = ST_NEXT;
			ST_NEXT: state_d = (i_q == AW'(NUM_WINDOWS - 1)) ? ST_DONE : ST_WIN;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		div_start = 1'b0;
		ram_we = 1'b0;
		ram_raddr = slot;
		load_out = 1'b0;
		unique case (state_q)
			ST_ROLL_RD: ram_raddr = head_q;
			ST_SAVE: div_start = need_align;
			ST_MUL: div_start = (mplier_q == '0);
			ST_ACC: ram_we = 1'b1;
			ST_DONE: load_out = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= STEP_W'(60);
			tmo_q <= SEC_W'(600);
			started_q <= 1'b0;
			db_q <= '0;
			head_q <= '0;
			vld_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_STEP: step_q <= cfg_data[STEP_W-1:0];
					REG_TIMEOUT: tmo_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_ROLL_EMIT) begin
				vld_q[head_q] <= 1'b0;
				db_q <= db_q + SEC_W'(s_eff);
				head_q <= (head_q == AW'(NUM_WINDOWS - 1)) ? '0 : head_q + 1'b1;
			end
			if (state_q == ST_ALIGN && div_st.done) begin
				db_q <= fs_q - SEC_W'(div_rem);
				head_q <= '0;
				vld_q <= '0;
				started_q <= 1'b1;
			end
			if (state_q == ST_ACC) begin
				vld_q[slot] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				fs_q <= start_sec;
				fm_q <= start_msec;
				ls_q <= end_sec;
				lm_q <= end_msec;
				val_q <= flow_value;
				res_status_q <= STAT_OK;
				res_begin_q <= '0;
				res_sum_q <= '0;
				res_count_q <= '0;
			end
			ST_ROLL_EMIT: begin
				res_begin_q <= db_q;
				res_sum_q <= vld_q[head_q] ? ram_rdata[ENT_W-1:CNT_W] : '0;
				res_count_q <= vld_q[head_q] ? ram_rdata[CNT_W-1:0] : '0;
			end
			ST_CHECK: begin
				if (end_w < WIN_W'(ls_q)) begin
					res_status_q <= STAT_ROLLOUT;
				end
				first_ms_q <= $signed(MS_W'(fs_q) * MS_W'(MS_PER_SEC) + MS_W'(fm_q));
				last_ms_q <= $signed(MS_W'(ls_q) * MS_W'(MS_PER_SEC) + MS_W'(lm_q));
				dur_q <= $signed(MS_W'(ls_q) * MS_W'(MS_PER_SEC) + MS_W'(lm_q))
					- $signed(MS_W'(fs_q) * MS_W'(MS_PER_SEC) + MS_W'(fm_q));
				i_q <= '0;
				wb_q <= WIN_W'(db_q);
			end
			ST_WIN: begin
				share_q <= SUM_W'(whole);
				mcand_q <= PROD_W'(whole);
				mplier_q <= ov_c;
				prod_q <= '0;
			end
			ST_MUL: begin
				if (mplier_q[0]) begin
					prod_q <= prod_q + mcand_q;
				end
				mcand_q <= {mcand_q[PROD_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[OV_W-1:1]};
			end
			ST_DIV: begin
				if (div_st.done) begin
					share_q <= div_quot[SUM_W-1:0];
				end
			end
			ST_NEXT: begin
				i_q <= i_q + 1'b1;
				wb_q <= we_w;
				if (i_q == AW'(NUM_WINDOWS - 1) && db_q > fs_q) begin
					res_status_q <= STAT_TRUNC;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status <= res_status_q;
			window_begin <= res_begin_q;
			window_sum <= $signed(res_sum_q);
			window_count <= res_count_q;
		end
	end

	assign out_valid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n) div_start |-> !div_st.busy)
		else $error("divider started while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_st.busy)
		else $error("divider busy with no word in flight");
	assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= AW'(NUM_WINDOWS - 1))
		else $error("ring head out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_ACC) && !in_stall == 1'b0)
		else $error("window write outside accumulate step");

endmodule

// ===== rtl/core/twfb_ram.sv =====
module twfb_ram #(
	parameter int unsigned WIDTH = 96,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/twfb_div.sv =====
module twfb_div import twfb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [OV_W-1:0]   divisor,
	output logic [PROD_W-1:0] quot,
	output logic [OV_W-1:0]   rem,
	output div_stat_t         stat
);

	logic [OV_W-1:0]      rem_q;
	logic [PROD_W-1:0]    dvd_q;
	logic [OV_W-1:0]      dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [OV_W+1:0]      trial;
	logic [OV_W:0]        shifted;

	// restoring divide, one quotient bit a cycle
	assign shifted = {rem_q, dvd_q[PROD_W-1]};
	assign trial = {1'b0, shifted} - {2'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[OV_W+1]) begin
				rem_q <= trial[OV_W-1:0];
			end else begin
				rem_q <= shifted[OV_W-1:0];
			end
			dvd_q <= {dvd_q[PROD_W-2:0], ~trial[OV_W+1]};
		end
	end

	assign quot = dvd_q;
	assign rem = rem_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule

// ===== tb/tb_time_window_flow_binner.sv =====
`timescale 1ns / 100ps

module tb_time_window_flow_binner import twfb_pkg::*;;

	localparam int NWIN = 8;
	localparam logic KIND_SAVE = 1'b0;
	localparam logic KIND_ROLL = 1'b1;

	typedef struct {
		logic              kind;
		logic [SEC_W-1:0]  fs;
		logic [MSEC_W-1:0] fm;
		logic [SEC_W-1:0]  ls;
		logic [MSEC_W-1:0] lm;
		logic [VAL_W-1:0]  val;
	} flow_word_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [SEC_W-1:0]    wbeg;
		logic [SUM_W-1:0]    sum;
		logic [CNT_W-1:0]    cnt;
	} window_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic                    kind;
	logic [SEC_W-1:0]        start_sec;
	logic [MSEC_W-1:0]       start_msec;
	logic [SEC_W-1:0]        end_sec;
	logic [MSEC_W-1:0]       end_msec;
	logic signed [VAL_W-1:0] flow_value;
	logic                    out_valid;
	logic                    out_stall;
	logic [STATUS_W-1:0]     status;
	logic [SEC_W-1:0]        window_begin;
	logic signed [SUM_W-1:0] window_sum;
	logic [CNT_W-1:0]        window_count;

	time_window_flow_binner #(.NUM_WINDOWS(NWIN)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .start_sec(start_sec), .start_msec(start_msec),
		.end_sec(end_sec), .end_msec(end_msec), .flow_value(flow_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .window_begin(window_begin),
		.window_sum(window_sum), .window_count(window_count)
	);

	// mirror of the binner state
	logic              m_started;
	logic [SEC_W-1:0]  m_db;
	int                m_head;
	logic [SUM_W-1:0]  m_sum [NWIN];
	logic [CNT_W-1:0]  m_cnt [NWIN];
	logic [STEP_W-1:0] m_step;
	logic [31:0]       m_tmo;

	window_result_t pending_q [$];
	int n_bad;
	int idle_pct;
	int stall_pct;
	logic hold_go;
	int hold_len;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#8ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [63:0] step_now();
		return (m_step == 0) ? 64'd1 : {47'd0, m_step};
	endfunction

	function automatic void realign(input logic [SEC_W-1:0] t);
		logic [63:0] s;
		s = step_now();
		m_db = 32'({32'd0, t} - {32'd0, t} % s);
		m_head = 0;
		for (int i = 0; i < NWIN; i++) begin
			m_sum[i] = '0;
			m_cnt[i] = '0;
		end
		m_started = 1'b1;
	endfunction

	function automatic window_result_t bin_word(input flow_word_t w);
		window_result_t r;
		logic [63:0] s, wb, we, mag, whole, share;
		logic [127:0] prod;
		longint fms, lms, dur, hi, lo, ov;
		int slot;
		r = '{status: STAT_OK, wbeg: '0, sum: '0, cnt: '0};
		s = step_now();
		if (w.kind == KIND_ROLL) begin
			slot = m_head;
			r.wbeg = m_db;
			r.sum = m_sum[slot];
			r.cnt = m_cnt[slot];
			m_sum[slot] = '0;
			m_cnt[slot] = '0;
			m_db = m_db + s[31:0];
			m_head = (slot + 1) % NWIN;
			return r;
		end
		if (!m_started)
			realign(w.fs);
		if (longint'({32'd0, w.fs}) - longint'({32'd0, m_db}) > longint'({32'd0, m_tmo}))
			realign(w.fs);
		s = step_now();
		if ({32'd0, m_db} + 64'(NWIN) * s < {32'd0, w.ls}) begin
			r.status = STAT_ROLLOUT;
			return r;
		end
		fms = longint'({32'd0, w.fs}) * 1000 + longint'({54'd0, w.fm});
		lms = longint'({32'd0, w.ls}) * 1000 + longint'({54'd0, w.lm});
		dur = lms - fms;
		mag = w.val[VAL_W-1] ? (64'h1_0000_0000_0000 - {16'd0, w.val}) : {16'd0, w.val};
		whole = mag << FRAC_BITS;
		for (int i = 0; i < NWIN; i++) begin
			wb = {32'd0, m_db} + 64'(i) * s;
			we = wb + s;
			slot = (m_head + i) % NWIN;
			if (!(wb <= {32'd0, w.ls} && we >= {32'd0, w.fs}))
				continue;
			if (dur <= 0) begin
				share = whole;
			end else begin
				hi = longint'(we * 1000);
				lo = longint'(wb * 1000);
				if (lms < hi) hi = lms;
				if (fms > lo) lo = fms;
				ov = hi - lo;
				if (ov < 0) ov = 0;
				prod = {64'd0, whole} * {64'd0, 64'(ov)};
				share = 64'(prod / {64'd0, 64'(dur)});
			end
			if (w.val[VAL_W-1])
				m_sum[slot] = m_sum[slot] - share;
			else
				m_sum[slot] = m_sum[slot] + share;
			m_cnt[slot] = m_cnt[slot] + 1;
		end
		if (m_db > w.fs)
			r.status = STAT_TRUNC;
		return r;
	endfunction

	// predict on every accepted word and register write
	always @(posedge clk) begin
		flow_word_t w;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_STEP)
					m_step = cfg_data[STEP_W-1:0];
				else
					m_tmo = cfg_data;
			end
			if (in_valid && !in_stall) begin
				w = '{kind, start_sec, start_msec, end_sec, end_msec, flow_value};
				pending_q.push_back(bin_word(w));
			end
		end
	end

	always @(posedge clk) begin
		window_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				if (n_bad < 10)
					$display("unexpected result word: status %0d begin %0d", status, window_begin);
				n_bad++;
			end else begin
				e = pending_q.pop_front();
				if (status !== e.status || window_begin !== e.wbeg ||
				    window_sum !== e.sum || window_count !== e.cnt) begin
					if (n_bad < 10)
						$display("mismatch: exp st %0d beg %0d sum %0d cnt %0d, got st %0d beg %0d sum %0d cnt %0d",
							e.status, e.wbeg, $signed(e.sum), e.cnt,
							status, window_begin, window_sum, window_count);
					n_bad++;
				end
			end
		end
	end

	always @(posedge clk)
		out_stall <= hold_go || ($urandom_range(99) < stall_pct);

	// long receiver hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_go) begin
				repeat (hold_len) @(posedge clk);
				hold_go = 1'b0;
			end
		end
	end

	task automatic send_word(input flow_word_t w);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		kind <= w.kind;
		start_sec <= w.fs;
		start_msec <= w.fm;
		end_sec <= w.ls;
		end_msec <= w.lm;
		flow_value <= w.val;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic save(input logic [31:0] fs, input logic [9:0] fm,
	                    input logic [31:0] ls, input logic [9:0] lm, input logic [47:0] val);
		send_word('{KIND_SAVE, fs, fm, ls, lm, val});
	endtask

	task automatic roll();
		send_word('{KIND_ROLL, $urandom, 10'($urandom_range(999)), $urandom,
			10'($urandom_range(999)), 48'({$urandom, $urandom})});
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic flow_word_t random_word();
		flow_word_t w;
		logic [63:0] s;
		logic [31:0] base;
		s = step_now();
		base = m_started ? m_db : $urandom;
		w.kind = KIND_SAVE;
		w.fm = 10'($urandom_range(999));
		w.lm = 10'($urandom_range(999));
		w.fs = base + 32'($urandom_range(0, 32'(8 * s)));
		if ($urandom_range(9) == 0)
			w.fs = w.fs - 32'($urandom_range(0, 32'(s)));
		case ($urandom_range(11))
			0: w.ls = w.fs;
			1: w.ls = w.fs - 32'($urandom_range(0, 3));
			2: w.ls = base + 32'(8 * s) + 32'($urandom_range(1, 32'(s)));
			3: begin
				w.fs = base + m_tmo + 32'($urandom_range(1, 1000));
				w.ls = w.fs + 32'($urandom_range(0, 32'(s)));
			end
			4: begin
				w.fs = $urandom;
				w.ls = w.fs + 32'($urandom_range(0, 32'(2 * s)));
			end
			default: begin
				w.ls = w.fs + 32'($urandom_range(0, 32'(2 * s)));
				if ({32'd0, w.ls} > {32'd0, base} + 8 * s && w.ls > w.fs)
					w.ls = base + 32'(8 * s);
			end
		endcase
		if ($urandom_range(1))
			w.val = 48'({$urandom, $urandom});
		else
			w.val = 48'($urandom_range(0, 2000)) * ($urandom_range(1) ? 48'd1 : -48'sd1);
		if ($urandom_range(3) == 0)
			w.kind = KIND_ROLL;
		return w;
	endfunction

	task automatic test_directed();
		idle_pct = 0;
		stall_pct = 0;
		roll();
		save(32'd1000, 10'd500, 32'd1100, 10'd250, 48'd1000);
		save(32'd1000, 10'd0, 32'd1000, 10'd0, -48'sd7);
		save(32'd1010, 10'd900, 32'd1005, 10'd100, 48'd123);
		save(32'd1000, 10'd0, 32'd1500, 10'd0, 48'd55);
		save(32'd1001, 10'd999, 32'd1440, 10'd999, 48'd999);
		roll();
		save(32'd1000, 10'd0, 32'd1030, 10'd0, 48'h7FFF_FFFF_FFFF);
		save(32'd1030, 10'd0, 32'd1400, 10'd0, 48'h8000_0000_0000);
		save(32'd1100, 10'd0, 32'd1100, 10'd0, 48'hFFFF_FFFF_FFFF);
		// idle gap forces realignment
		save(32'd2000, 10'd0, 32'd2010, 10'd0, 48'd5);
		roll();
		roll();
		roll();
		save(32'hFFFF_FFF0, 10'd999, 32'hFFFF_FFFF, 10'd999, 48'h5555_5555_5555);
		save(32'hFFFF_FFF0, 10'd0, 32'hFFFF_FFFF, 10'd512, 48'hAAAA_AAAA_AAAA);
		// db_begin wraps past zero
		roll();
		roll();
		save(32'd50, 10'd0, 32'd60, 10'd0, 48'd77);
		roll();
		drain();
	endtask

	task automatic test_random(input logic [31:0] step, input logic [31:0] tmo,
	                           input int idle, input int stall, input int n);
		write_reg(REG_STEP, step);
		write_reg(REG_TIMEOUT, tmo);
		idle_pct = idle;
		stall_pct = stall;
		repeat (n) send_word(random_word());
		drain();
	endtask

	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		hold_len = 400;
		hold_go = 1'b1;
		repeat (8) send_word(random_word());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = 1'b0;
		start_sec = '0;
		start_msec = '0;
		end_sec = '0;
		end_msec = '0;
		flow_value = '0;
		out_stall = 1'b0;
		hold_go = 1'b0;
		hold_len = 0;
		idle_pct = 0;
		stall_pct = 0;
		n_bad = 0;
		m_started = 1'b0;
		m_db = '0;
		m_head = 0;
		m_step = 17'd60;
		m_tmo = 32'd600;
		for (int i = 0; i < NWIN; i++) begin
			m_sum[i] = '0;
			m_cnt[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(32'd60, 32'd600, 0, 0, 80);
		test_random(32'd1, 32'd0, 82, 0, 70);
		test_random(32'd86400, 32'hFFFF_FFFF, 0, 82, 70);
		test_random(32'd0, 32'd100, 7, 7, 70);
		test_backpressure();
		test_random(32'd7, 32'd50, 0, 0, 70);
		test_random(32'd60, 32'd600, 7, 7, 60);
		repeat (50) @(posedge clk);
		if (n_bad == 0 && pending_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== time_window_flow_binner.f =====
rtl/core/twfb_pkg.sv
rtl/core/twfb_ram.sv
rtl/core/twfb_div.sv
rtl/core/time_window_flow_binner.sv
tb/tb_time_window_flow_binner.sv
